// ===== rtl/core/jkvl_pkg.sv =====
// Package for the JSON key/value locator: widths, character codes, phase and status types.
`default_nettype none
package jkvl_pkg;

   localparam int BYTE_W    = 8;
   localparam int KEY_W     = 64;
   localparam int KLEN_W    = 4;
   localparam int OFF_W     = 16;
   localparam int LEN_W     = 17;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_DOC_BYTES = 65536;
   localparam int DEF_MAX_DEPTH     = 255;
   localparam int DEF_MAX_KEY_BYTES = 8;

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

   typedef enum logic [3:0] {
      PH_OPEN,
      PH_KEYSTART,
      PH_KEY,
      PH_COLON,
      PH_VALSTART,
      PH_MSTR,
      PH_MNEST,
      PH_MRAW,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_NONE   = 2'd1,
      ST_UNTERM = 2'd2,
      ST_DEEP   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_CHARS  = 1'b0,
      REG_KEY_LENGTH = 1'b1
   } csr_reg_type;

   typedef struct packed {
      status_type         status;
      logic [OFF_W-1:0]   value_offset;
      logic [LEN_W-1:0]   value_length;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/jkvl_if.sv =====
// Channel interfaces: byte input, result output and register write port.
`default_nettype none
interface jkvl_req_if;
   import jkvl_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface jkvl_rsp_if;
   import jkvl_pkg::*;
   logic             valid;
   logic             ready;
   status_type       status;
   logic [OFF_W-1:0] value_offset;
   logic [LEN_W-1:0] value_length;
   modport source (output valid, status, value_offset, value_length, input ready);
   modport sink   (input valid, status, value_offset, value_length, output ready);
endinterface

interface jkvl_csr_if;
   import jkvl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [KEY_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jkvl_scan.sv =====
// Per-byte parser: document state registers and the decision logic for one byte.
`default_nettype none
module jkvl_scan #(
   parameter int MAX_DOC_BYTES = jkvl_pkg::DEF_MAX_DOC_BYTES,
   parameter int MAX_DEPTH     = jkvl_pkg::DEF_MAX_DEPTH,
   parameter int MAX_KEY_BYTES = jkvl_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [jkvl_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic                          last_byte,
   input  wire logic [jkvl_pkg::KEY_W-1:0]    key_chars,
   input  wire logic [jkvl_pkg::KLEN_W-1:0]   key_length,
   output logic                               res_valid,
   output jkvl_pkg::result_type               res
);
   import jkvl_pkg::*;

   localparam int PW  = $clog2(MAX_DOC_BYTES + 1);
   localparam int DW  = $clog2(MAX_DEPTH + 1);
   localparam int KIW = $clog2(MAX_KEY_BYTES + 1);

   phase_type        phase_ff, phase_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [KIW-1:0]   kidx_ff, kidx_in;
   logic             keq_ff, keq_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic             instr_ff, instr_in;
   logic             bs_ff, bs_in;
   logic [PW-1:0]    vstart_ff, vstart_in;
   logic             decided_ff, decided_in;

   logic is_ws, is_open, is_close, is_comma, is_quote, is_bsl;
   logic [KLEN_W-1:0] kl;
   logic [2:0]        ksel;
   logic [BYTE_W-1:0] key_byte;
   logic              cmp_hit;
   logic [PW-1:0]     pos_inc;

   // nesting tracker inputs and outputs
   logic          n_in, n_bs;
   logic [DW-1:0] n_depth;
   logic [PW-1:0] vs_src;
   logic          trk_instr, trk_bs, trk_deep, trk_under;
   logic [DW-1:0] trk_depth;

   phase_type     cn_phase;
   logic [KIW-1:0] cn_kidx;
   logic          cn_keq, cn_instr, cn_bs;
   logic [DW-1:0] cn_depth;
   logic [PW-1:0] cn_vstart;
   logic          c_emit;
   status_type    c_st;
   logic [PW-1:0] c_off, c_len;

   phase_type     f_phase;
   logic [PW-1:0] f_pos, f_vs;
   logic          f_keq;
   status_type    f_st;
   logic [PW-1:0] f_off, f_len;

   logic          raw_emit;
   status_type    raw_st;
   logic [PW-1:0] raw_off, raw_len;
   logic          ovf;

   assign is_ws    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                     (data_byte == CH_LF) || (data_byte == CH_CR);
   assign is_open  = (data_byte == CH_LBRACE) || (data_byte == CH_LBRACK);
   assign is_close = (data_byte == CH_RBRACE) || (data_byte == CH_RBRACK);
   assign is_comma = (data_byte == CH_COMMA);
   assign is_quote = (data_byte == CH_QUOTE);
   assign is_bsl   = (data_byte == CH_BSLASH);

   assign kl       = (key_length > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES) : key_length;
   assign ksel     = 3'(kidx_ff);
   assign key_byte = key_chars[{ksel, 3'b000} +: BYTE_W];
   assign cmp_hit  = keq_ff && (KLEN_W'(kidx_ff) < kl) && (key_byte == data_byte);
   assign pos_inc  = PW'(pos_ff + 1'b1);

   // a skipped value starts with clean string and depth state
   assign n_in    = (phase_ff == PH_VALSTART) ? 1'b0 : instr_ff;
   assign n_bs    = (phase_ff == PH_VALSTART) ? 1'b0 : bs_ff;
   assign n_depth = (phase_ff == PH_VALSTART) ? '0 : depth_ff;
   assign vs_src  = (phase_ff == PH_VALSTART) ? pos_ff : vstart_ff;

   always_comb begin
      trk_instr = n_in;
      trk_bs    = n_bs;
      trk_depth = n_depth;
      trk_deep  = 1'b0;
      trk_under = 1'b0;
      if (n_in) begin
         if (n_bs) begin
            trk_bs = 1'b0;
         end else if (is_bsl) begin
            trk_bs = 1'b1;
         end else if (is_quote) begin
            trk_instr = 1'b0;
         end
      end else if (is_quote) begin
         trk_instr = 1'b1;
         trk_bs    = 1'b0;
      end else if (is_open) begin
         if (n_depth >= DW'(MAX_DEPTH)) begin
            trk_deep = 1'b1;
         end else begin
            trk_depth = DW'(n_depth + 1'b1);
         end
      end else if (is_close) begin
         if (n_depth == '0) begin
            trk_under = 1'b1;
         end else begin
            trk_depth = DW'(n_depth - 1'b1);
         end
      end
   end

   // consume one non-zero byte
   always_comb begin
      cn_phase  = phase_ff;
      cn_kidx   = kidx_ff;
      cn_keq    = keq_ff;
      cn_depth  = depth_ff;
      cn_instr  = instr_ff;
      cn_bs     = bs_ff;
      cn_vstart = vstart_ff;
      c_emit    = 1'b0;
      c_st      = ST_NONE;
      c_off     = '0;
      c_len     = '0;
      unique case (phase_ff)
         PH_OPEN: begin
            if (!is_ws) begin
               if (data_byte == CH_LBRACE) begin
                  cn_phase = PH_KEYSTART;
               end else begin
                  c_emit = 1'b1;
               end
            end
         end
         PH_KEYSTART: begin
            if (!is_ws) begin
               if (is_quote) begin
                  cn_phase = PH_KEY;
                  cn_kidx  = '0;
                  cn_keq   = 1'b1;
                  cn_bs    = 1'b0;
               end else begin
                  c_emit = 1'b1;
               end
            end
         end
         PH_KEY: begin
            if (!bs_ff && is_quote) begin
               cn_keq   = keq_ff && (KLEN_W'(kidx_ff) == kl);
               cn_phase = PH_COLON;
            end else begin
               if (bs_ff) begin
                  cn_bs = 1'b0;
               end else if (is_bsl) begin
                  cn_bs = 1'b1;
               end
               if (cmp_hit) begin
                  cn_kidx = KIW'(kidx_ff + 1'b1);
               end else begin
                  cn_keq = 1'b0;
               end
            end
         end
         PH_COLON: begin
            if (!is_ws) begin
               if (data_byte == CH_COLON) begin
                  cn_phase = PH_VALSTART;
               end else begin
                  c_emit = 1'b1;
               end
            end
         end
         PH_VALSTART, PH_SKIP: begin
            if (phase_ff == PH_VALSTART && is_ws) begin
               cn_phase = PH_VALSTART;
            end else if (phase_ff == PH_VALSTART && keq_ff) begin
               cn_vstart = pos_ff;
               cn_instr  = 1'b0;
               cn_bs     = 1'b0;
               if (is_quote) begin
                  cn_phase = PH_MSTR;
               end else if (is_open) begin
                  cn_depth = DW'(1);
                  cn_phase = PH_MNEST;
               end else if (is_close || is_comma) begin
                  c_emit = 1'b1;
                  c_st   = ST_FOUND;
                  c_off  = pos_ff;
               end else begin
                  cn_phase = PH_MRAW;
               end
            end else begin
               // skipping a value that belongs to another key
               cn_vstart = vs_src;
               cn_instr  = n_in;
               cn_bs     = n_bs;
               cn_depth  = n_depth;
               cn_phase  = PH_SKIP;
               if (!n_in && is_comma && n_depth == '0) begin
                  cn_phase = PH_KEYSTART;
               end else if (trk_deep) begin
                  c_emit = 1'b1;
                  c_st   = ST_DEEP;
                  c_off  = vs_src;
               end else if (trk_under) begin
                  c_emit = 1'b1;
               end else begin
                  cn_instr = trk_instr;
                  cn_bs    = trk_bs;
                  cn_depth = trk_depth;
               end
            end
         end
         PH_MSTR: begin
            if (bs_ff) begin
               cn_bs = 1'b0;
            end else if (is_bsl) begin
               cn_bs = 1'b1;
            end else if (is_quote) begin
               c_emit = 1'b1;
               c_st   = ST_FOUND;
               c_off  = vstart_ff;
               c_len  = PW'(pos_ff - vstart_ff + 1'b1);
            end
         end
         PH_MNEST: begin
            if (trk_deep) begin
               c_emit = 1'b1;
               c_st   = ST_DEEP;
               c_off  = vstart_ff;
            end else begin
               cn_instr = trk_instr;
               cn_bs    = trk_bs;
               cn_depth = trk_depth;
               if (!instr_ff && is_close && trk_depth == '0) begin
                  c_emit = 1'b1;
                  c_st   = ST_FOUND;
                  c_off  = vstart_ff;
                  c_len  = PW'(pos_ff - vstart_ff + 1'b1);
               end
            end
         end
         PH_MRAW: begin
            if (is_comma || is_close || is_ws) begin
               c_emit = 1'b1;
               c_st   = ST_FOUND;
               c_off  = vstart_ff;
               c_len  = PW'(pos_ff - vstart_ff);
            end
         end
         default: begin
            c_emit = 1'b1;
         end
      endcase
   end

   // end of document, either on a zero byte or after the last byte
   always_comb begin
      if (data_byte == CH_NUL) begin
         f_phase = phase_ff;
         f_pos   = pos_ff;
         f_keq   = keq_ff;
         f_vs    = vstart_ff;
      end else begin
         f_phase = cn_phase;
         f_pos   = pos_inc;
         f_keq   = cn_keq;
         f_vs    = cn_vstart;
      end
      f_st  = ST_NONE;
      f_off = '0;
      f_len = '0;
      unique case (f_phase)
         PH_VALSTART: begin
            if (f_keq) begin
               f_st  = ST_FOUND;
               f_off = f_pos;
            end
         end
         PH_MSTR: begin
            f_st  = ST_UNTERM;
            f_off = f_vs;
            f_len = PW'(f_pos - f_vs);
         end
         PH_MRAW: begin
            f_st  = ST_FOUND;
            f_off = f_vs;
            f_len = PW'(f_pos - f_vs);
         end
         default: begin
            f_st = ST_NONE;
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      kidx_in    = kidx_ff;
      keq_in     = keq_ff;
      depth_in   = depth_ff;
      instr_in   = instr_ff;
      bs_in      = bs_ff;
      vstart_in  = vstart_ff;
      decided_in = decided_ff;
      raw_emit   = 1'b0;
      raw_st     = ST_NONE;
      raw_off    = '0;
      raw_len    = '0;
      if (!decided_ff) begin
         priority if (data_byte == CH_NUL) begin
            raw_emit = 1'b1;
            raw_st   = f_st;
            raw_off  = f_off;
            raw_len  = f_len;
         end else if (pos_ff >= PW'(MAX_DOC_BYTES)) begin
            raw_emit = 1'b1;
         end else begin
            phase_in  = cn_phase;
            pos_in    = pos_inc;
            kidx_in   = cn_kidx;
            keq_in    = cn_keq;
            depth_in  = cn_depth;
            instr_in  = cn_instr;
            bs_in     = cn_bs;
            vstart_in = cn_vstart;
            if (c_emit) begin
               raw_emit = 1'b1;
               raw_st   = c_st;
               raw_off  = c_off;
               raw_len  = c_len;
            end else if (last_byte) begin
               raw_emit = 1'b1;
               raw_st   = f_st;
               raw_off  = f_off;
               raw_len  = f_len;
            end
         end
         if (raw_emit) begin
            decided_in = 1'b1;
         end
      end
      if (last_byte) begin
         phase_in   = PH_OPEN;
         pos_in     = '0;
         kidx_in    = '0;
         keq_in     = 1'b1;
         depth_in   = '0;
         instr_in   = 1'b0;
         bs_in      = 1'b0;
         vstart_in  = '0;
         decided_in = 1'b0;
      end
   end

   // results that do not fit their fields are reported as not found
   always_comb begin
      ovf = (32'(raw_off) > 32'h0000_FFFF) || (32'(raw_len) > 32'h0001_FFFF);
      res.status       = raw_st;
      res.value_offset = OFF_W'(raw_off);
      res.value_length = LEN_W'(raw_len);
      if (raw_st == ST_NONE || ovf) begin
         res.status       = ST_NONE;
         res.value_offset = '0;
         res.value_length = '0;
      end
   end

   assign res_valid = raw_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPEN;
         pos_ff     <= '0;
         kidx_ff    <= '0;
         keq_ff     <= 1'b1;
         depth_ff   <= '0;
         instr_ff   <= 1'b0;
         bs_ff      <= 1'b0;
         vstart_ff  <= '0;
         decided_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         kidx_ff    <= kidx_in;
         keq_ff     <= keq_in;
         depth_ff   <= depth_in;
         instr_ff   <= instr_in;
         bs_ff      <= bs_in;
         vstart_ff  <= vstart_in;
         decided_ff <= decided_in;
      end
   end

`ifndef SYNTHESIS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && !last_byte |=> decided_ff)
      else $error("result given but document not marked decided");
   a_no_result_after: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> !res_valid)
      else $error("second result for one document");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_DEPTH))
      else $error("nesting depth above limit");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_DOC_BYTES))
      else $error("byte position beyond document limit");
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> phase_ff == PH_OPEN && pos_ff == '0 && !decided_ff)
      else $error("last byte did not re-arm the parser");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/json_key_value_locator_unit.sv =====
// Top level of the JSON key/value locator: channels, key registers, input and result stages.
//
//  channel   | dir | payload                                   | transaction
//  req_chan  | in  | data_byte[7:0], last_byte                 | one document byte
//  rsp_chan  | out | status[1:0], value_offset[15:0],          | one result per document
//            |     | value_length[16:0]                        |
//  csr_chan  | in  | index (0 key_chars, 1 key_length), data   | one register write
//
// One byte per cycle sustained. A byte is registered in the input stage on acceptance and
// then parsed, and the byte that decides a result writes it into the result register.
// The parser state registers close the only per-byte loop.
// Input stalls only when the byte in the input stage gives a result while the result
// register is full and not being taken. Reset is synchronous; it clears the key
// registers and returns the parser to waiting for the opening brace.
`default_nettype none
module json_key_value_locator_unit #(
   parameter int MAX_DOC_BYTES = jkvl_pkg::DEF_MAX_DOC_BYTES,
   parameter int MAX_DEPTH     = jkvl_pkg::DEF_MAX_DEPTH,
   parameter int MAX_KEY_BYTES = jkvl_pkg::DEF_MAX_KEY_BYTES
) (
   input wire logic   clock,
   input wire logic   reset,
   jkvl_req_if.sink   req_chan,
   jkvl_rsp_if.source rsp_chan,
   jkvl_csr_if.sink   csr_chan
);
   import jkvl_pkg::*;

   logic [KEY_W-1:0]  key_chars_ff;
   logic [KLEN_W-1:0] key_length_ff;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   logic              out_valid_ff;
   result_type        out_res_ff;

   logic       advance;
   logic       res_valid;
   result_type res;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_chars_ff  <= '0;
         key_length_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_reg_type'(csr_chan.index))
            REG_KEY_CHARS:  key_chars_ff  <= csr_chan.data;
            REG_KEY_LENGTH: key_length_ff <= csr_chan.data[KLEN_W-1:0];
            default:        key_chars_ff  <= key_chars_ff;
         endcase
      end
   end

   // a byte that gives no result may move on even while the result stage is held
   assign advance        = in_valid_ff && (!res_valid || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   jkvl_scan #(
      .MAX_DOC_BYTES (MAX_DOC_BYTES),
      .MAX_DEPTH     (MAX_DEPTH),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .key_chars  (key_chars_ff),
      .key_length (key_length_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_res_ff.status;
   assign rsp_chan.value_offset = out_res_ff.value_offset;
   assign rsp_chan.value_length = out_res_ff.value_length;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the JSON key/value locator: directed and random documents.
`timescale 1ns / 100ps
module testbench;
   import jkvl_pkg::*;

   localparam int unsigned MAX_DOC     = DEF_MAX_DOC_BYTES;
   localparam int unsigned MAX_NEST    = DEF_MAX_DEPTH;
   localparam int unsigned MAX_KEY     = DEF_MAX_KEY_BYTES;
   localparam int          CYCLE_LIMIT = 30000;
   localparam logic [KEY_W-1:0] KEY_K  = 64'h6B;
   localparam logic [KEY_W-1:0] KEY_AH = 64'h6867_6665_6463_6261;

   typedef logic [BYTE_W-1:0] doc_bytes_type[$];

   typedef struct {
      string            text;
      int               zero_at;
      bit               typed;
      status_type       st;
      int unsigned      off;
      int unsigned      len;
      bit               rekey;
      logic [KEY_W-1:0] kc;
      logic [3:0]       kl;
   } doc_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jkvl_req_if req ();
   jkvl_rsp_if rsp ();
   jkvl_csr_if csr ();

   json_key_value_locator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // locator model state
   logic [KEY_W-1:0] key_chars_reg = '0;
   logic [3:0]       key_len_reg   = '0;
   phase_type        stage         = PH_OPEN;
   int unsigned      doc_pos       = 0;
   int unsigned      key_hits      = 0;
   bit               key_alive     = 1'b1;
   int unsigned      depth         = 0;
   bit               in_quotes     = 1'b0;
   bit               escaped       = 1'b0;
   int unsigned      val_begin     = 0;
   bit               settled       = 1'b0;
   result_type       outcome;
   bit               outcome_ready;

   result_type       expected_locations[$];
   result_type       typed_result;
   bit               typed_on      = 1'b0;
   doc_bytes_type    doc_text;
   bit               quiet         = 1'b0;
   bit               hold_request  = 1'b0;
   int unsigned      live_bytes    = 0;
   int               mismatches    = 0;
   int               cycle_count   = 0;

   doc_row_type directed_docs [24] = '{
      '{"{\"\":7}", -1, 1'b1, ST_FOUND, 4, 1, 1'b0, '0, 4'd0},
      '{"{\"a\":1}", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{" \t\n{\"k\":\"v\\\"x\"}", -1, 1'b0, ST_NONE, 0, 0, 1'b1, KEY_K, 4'd1},
      '{"{\"k\":[1,{\"a\":\"]\"}],\"z\":0}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"a\":{\"k\":1},\"k\":true}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"k\":,}", -1, 1'b1, ST_FOUND, 5, 0, 1'b0, '0, 4'd0},
      '{"{\"k\":", -1, 1'b1, ST_FOUND, 5, 0, 1'b0, '0, 4'd0},
      '{"{\"k\":\"abc", -1, 1'b1, ST_UNTERM, 5, 4, 1'b0, '0, 4'd0},
      '{"{\"k\":12", -1, 1'b1, ST_FOUND, 5, 2, 1'b0, '0, 4'd0},
      '{"[1]", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"kk\":1}", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"k\" x", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"k\":1#x}", 6, 1'b1, ST_FOUND, 5, 1, 1'b0, '0, 4'd0},
      '{"{\"k\":1}xyz", -1, 1'b1, ST_FOUND, 5, 1, 1'b0, '0, 4'd0},
      '{"{\"k\":{\"a\":[1]}}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"b\":\"x,}\",\"k\":\"q\"}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"a\":1]", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"k\":[1}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"\\k\":1}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{}", -1, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"#{\"k\":1}", 0, 1'b1, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"abcdefgh\":\"x\"}", -1, 1'b0, ST_NONE, 0, 0, 1'b1, KEY_AH, 4'd15},
      '{"{\"abcdefghi\":1,\"abcdefgh\":[]}", -1, 1'b0, ST_NONE, 0, 0, 1'b0, '0, 4'd0},
      '{"{\"a\\\"b\":{\"c\":\"}\"},\"abcdefgh\" : 5 }", -1, 1'b0, ST_NONE, 0, 0,
        1'b0, '0, 4'd0}
   };

   // ---------------------------------------------------------------- locator model

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic bit is_closer(logic [7:0] c);
      return c == CH_RBRACE || c == CH_RBRACK;
   endfunction

   function automatic int unsigned key_bytes_used();
      return (key_len_reg > MAX_KEY) ? MAX_KEY : key_len_reg;
   endfunction

   function automatic void report(status_type st, int unsigned off, int unsigned span);
      if (st != ST_NONE && (off > 32'hFFFF || span > 32'h1FFFF))
         st = ST_NONE;
      if (st == ST_NONE) begin
         off  = 0;
         span = 0;
      end
      outcome.status       = st;
      outcome.value_offset = OFF_W'(off);
      outcome.value_length = LEN_W'(span);
      outcome_ready        = 1'b1;
      settled              = 1'b1;
   endfunction

   function automatic void restart_document();
      stage     = PH_OPEN;
      doc_pos   = 0;
      key_hits  = 0;
      key_alive = 1'b1;
      depth     = 0;
      in_quotes = 1'b0;
      escaped   = 1'b0;
      val_begin = 0;
      settled   = 1'b0;
   endfunction

   function automatic void match_key_byte(logic [7:0] c);
      if (key_alive && key_hits < key_bytes_used() && key_chars_reg[8*key_hits +: 8] == c)
         key_hits++;
      else
         key_alive = 1'b0;
   endfunction

   // 0 ok, -1 nesting too deep, -2 closer with nothing open
   function automatic int follow_brackets(logic [7:0] c);
      if (in_quotes) begin
         if (escaped)
            escaped = 1'b0;
         else if (c == CH_BSLASH)
            escaped = 1'b1;
         else if (c == CH_QUOTE)
            in_quotes = 1'b0;
         return 0;
      end
      if (c == CH_QUOTE) begin
         in_quotes = 1'b1;
         escaped   = 1'b0;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
         if (depth >= MAX_NEST)
            return -1;
         depth++;
      end else if (is_closer(c)) begin
         if (depth == 0)
            return -2;
         depth--;
      end
      return 0;
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      int t;
      bit was_quoted;
      case (stage)
         PH_OPEN: begin
            if (c == CH_LBRACE)
               stage = PH_KEYSTART;
            else if (!is_blank(c))
               report(ST_NONE, 0, 0);
         end
         PH_KEYSTART: begin
            if (c == CH_QUOTE) begin
               stage     = PH_KEY;
               key_hits  = 0;
               key_alive = 1'b1;
               escaped   = 1'b0;
            end else if (!is_blank(c)) begin
               report(ST_NONE, 0, 0);
            end
         end
         PH_KEY: begin
            if (escaped) begin
               escaped = 1'b0;
               match_key_byte(c);
            end else if (c == CH_BSLASH) begin
               escaped = 1'b1;
               match_key_byte(c);
            end else if (c == CH_QUOTE) begin
               key_alive = key_alive && key_hits == key_bytes_used();
               stage     = PH_COLON;
            end else begin
               match_key_byte(c);
            end
         end
         PH_COLON: begin
            if (c == CH_COLON)
               stage = PH_VALSTART;
            else if (!is_blank(c))
               report(ST_NONE, 0, 0);
         end
         PH_VALSTART: begin
            if (!is_blank(c)) begin
               val_begin = doc_pos;
               in_quotes = 1'b0;
               escaped   = 1'b0;
               if (key_alive) begin
                  if (c == CH_QUOTE) begin
                     stage = PH_MSTR;
                  end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                     depth = 1;
                     stage = PH_MNEST;
                  end else if (c == CH_COMMA || is_closer(c)) begin
                     report(ST_FOUND, doc_pos, 0);
                  end else begin
                     stage = PH_MRAW;
                  end
               end else begin
                  // a non-matching value starts being skipped with this very byte
                  depth = 0;
                  stage = PH_SKIP;
                  parse_byte(c);
               end
            end
         end
         PH_MSTR: begin
            if (escaped)
               escaped = 1'b0;
            else if (c == CH_BSLASH)
               escaped = 1'b1;
            else if (c == CH_QUOTE)
               report(ST_FOUND, val_begin, doc_pos - val_begin + 1);
         end
         PH_MNEST: begin
            was_quoted = in_quotes;
            t = follow_brackets(c);
            if (t == -1)
               report(ST_DEEP, val_begin, 0);
            else if (!was_quoted && is_closer(c) && depth == 0)
               report(ST_FOUND, val_begin, doc_pos - val_begin + 1);
         end
         PH_MRAW: begin
            if (c == CH_COMMA || is_closer(c) || is_blank(c))
               report(ST_FOUND, val_begin, doc_pos - val_begin);
         end
         PH_SKIP: begin
            if (!in_quotes && c == CH_COMMA && depth == 0) begin
               stage = PH_KEYSTART;
            end else begin
               t = follow_brackets(c);
               if (t == -1)
                  report(ST_DEEP, val_begin, 0);
               else if (t == -2)
                  report(ST_NONE, 0, 0);
            end
         end
         default: report(ST_NONE, 0, 0);
      endcase
   endfunction

   function automatic void close_document();
      case (stage)
         PH_VALSTART: begin
            if (key_alive)
               report(ST_FOUND, doc_pos, 0);
            else
               report(ST_NONE, 0, 0);
         end
         PH_MSTR: report(ST_UNTERM, val_begin, doc_pos - val_begin);
         PH_MRAW: report(ST_FOUND, val_begin, doc_pos - val_begin);
         default: report(ST_NONE, 0, 0);
      endcase
   endfunction

   function automatic bit locate_byte(logic [7:0] c, bit last);
      outcome_ready = 1'b0;
      if (!settled) begin
         if (c == CH_NUL) begin
            close_document();
         end else if (doc_pos >= MAX_DOC) begin
            report(ST_NONE, 0, 0);
         end else begin
            parse_byte(c);
            doc_pos++;
            if (!settled && last)
               close_document();
         end
      end
      if (last)
         restart_document();
      return outcome_ready;
   endfunction

   // ---------------------------------------------------------------- document builder

   function automatic void load_text(string s);
      doc_text.delete();
      for (int i = 0; i < s.len(); i++)
         doc_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic void put_blanks();
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 2)) doc_text.push_back(blank_char());
   endfunction

   // nonzero, never a bare quote or backslash
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0)
         c = 8'($urandom_range(1, 255));
      else
         c = 8'($urandom_range(8'h61, 8'h7A));
      if (c == CH_QUOTE || c == CH_BSLASH)
         c = 8'h2E;
      return c;
   endfunction

   function automatic void put_text(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            doc_text.push_back(CH_BSLASH);
            doc_text.push_back(8'($urandom_range(1, 255)));
         end else begin
            doc_text.push_back(text_char());
         end
      end
   endfunction

   function automatic void put_key();
      int unsigned kl;
      int unsigned pick;
      kl   = key_bytes_used();
      pick = $urandom_range(0, 5);
      doc_text.push_back(CH_QUOTE);
      if (pick <= 4) begin
         // configured key, as is, with one byte more, or one byte short
         for (int i = 0; i < kl; i++)
            if (!(pick == 4 && i == kl - 1))
               doc_text.push_back(key_chars_reg[8*i +: 8]);
         if (pick == 3)
            doc_text.push_back(text_char());
      end else begin
         put_text($urandom_range(0, 4));
      end
      doc_text.push_back(CH_QUOTE);
   endfunction

   function automatic void put_value(int level);
      logic [7:0] opener;
      int         n;
      case ($urandom_range(0, (level < 3) ? 6 : 3))
         0: begin
            doc_text.push_back(CH_QUOTE);
            put_text($urandom_range(0, 5));
            doc_text.push_back(CH_QUOTE);
         end
         1: repeat ($urandom_range(1, 5)) doc_text.push_back(text_char());
         2: ;  // empty value
         3: doc_text.push_back(8'($urandom_range(8'h30, 8'h39)));
         default: begin
            opener = ($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_LBRACK;
            doc_text.push_back(opener);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0)
                  doc_text.push_back(CH_COMMA);
               put_blanks();
               if (opener == CH_LBRACE) begin
                  put_key();
                  doc_text.push_back(CH_COLON);
               end
               put_value(level + 1);
            end
            put_blanks();
            // mostly the matching closer, sometimes the other kind
            if (($urandom_range(0, 5) == 0) ^ (opener == CH_LBRACE))
               doc_text.push_back(CH_RBRACE);
            else
               doc_text.push_back(CH_RBRACK);
         end
      endcase
   endfunction

   function automatic void build_doc();
      int n;
      int keep;
      doc_text.delete();
      put_blanks();
      doc_text.push_back(CH_LBRACE);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            doc_text.push_back(CH_COMMA);
         put_blanks();
         put_key();
         put_blanks();
         doc_text.push_back(CH_COLON);
         put_blanks();
         put_value(0);
         put_blanks();
      end
      doc_text.push_back(CH_RBRACE);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) doc_text.push_back(text_char());
      case ($urandom_range(0, 9))
         0: doc_text[$urandom_range(0, doc_text.size() - 1)] = 8'($urandom_range(0, 255));
         1: begin
            keep = $urandom_range(1, doc_text.size());
            while (doc_text.size() > keep)
               void'(doc_text.pop_back());
         end
         2: begin
            doc_text.delete();
            repeat ($urandom_range(1, 10)) doc_text.push_back(8'($urandom_range(0, 255)));
         end
         3: doc_text[$urandom_range(0, doc_text.size() - 1)] = CH_NUL;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- channel drivers

   task automatic send_byte(input logic [7:0] c, input bit last);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid = 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req.valid     = 1'b1;
      req.data_byte = c;
      req.last_byte = last;
      do @(posedge clock); while (req.ready !== 1'b1);
      if (!settled)
         live_bytes++;
      if (locate_byte(c, last))
         expected_locations.push_back(typed_on ? typed_result : outcome);
      @(negedge clock);
   endtask

   task automatic send_doc();
      foreach (doc_text[k])
         send_byte(doc_text[k], k == doc_text.size() - 1);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [KEY_W-1:0] val);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = val;
      do @(posedge clock); while (csr.ready !== 1'b1);
      if (idx == REG_KEY_CHARS)
         key_chars_reg = val;
      else
         key_len_reg = val[3:0];
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // key registers only change with the block drained
   task automatic set_key(input logic [KEY_W-1:0] chars, input logic [3:0] kl);
      req.valid = 1'b0;
      wait (expected_locations.size() == 0);
      repeat (8) @(negedge clock);
      write_reg(REG_KEY_CHARS, chars);
      write_reg(REG_KEY_LENGTH, KEY_W'(kl));
   endtask

   // result sink: random stalls plus one long hold-off to back the block up
   initial begin
      int gap;
      rsp.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp.ready = 1'b0;
            repeat (150) @(negedge clock);
            hold_request = 1'b0;
            rsp.ready    = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp.ready = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clock);
            rsp.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_locations.size() == 0) begin
            $error("unexpected result transaction: status %0d offset %0d length %0d",
                   rsp.status, rsp.value_offset, rsp.value_length);
            mismatches++;
         end else begin
            want = expected_locations.pop_front();
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               mismatches++;
            end
            if (rsp.value_offset !== want.value_offset) begin
               $error("value_offset: expected %0d, got %0d",
                      want.value_offset, rsp.value_offset);
               mismatches++;
            end
            if (rsp.value_length !== want.value_length) begin
               $error("value_length: expected %0d, got %0d",
                      want.value_length, rsp.value_length);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] kc;
      logic [3:0]       kl;
      int unsigned      start;
      int               docs;
      req.valid     = 1'b0;
      req.data_byte = '0;
      req.last_byte = 1'b0;
      csr.valid     = 1'b0;
      csr.index     = REG_KEY_CHARS;
      csr.data      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed documents; the first two run on the key registers' reset values
      foreach (directed_docs[i]) begin
         if (directed_docs[i].rekey)
            set_key(directed_docs[i].kc, directed_docs[i].kl);
         load_text(directed_docs[i].text);
         if (directed_docs[i].zero_at >= 0)
            doc_text[directed_docs[i].zero_at] = CH_NUL;
         typed_on                  = directed_docs[i].typed;
         typed_result.status       = directed_docs[i].st;
         typed_result.value_offset = OFF_W'(directed_docs[i].off);
         typed_result.value_length = LEN_W'(directed_docs[i].len);
         send_doc();
      end
      typed_on = 1'b0;

      // nesting beyond the depth limit inside the matched value
      set_key(KEY_K, 4'd1);
      load_text("{\"k\":");
      repeat (MAX_NEST + 1) doc_text.push_back(CH_LBRACK);
      doc_text.push_back(CH_RBRACE);
      send_doc();

      // random documents over a series of keys; no idling in the last series
      for (int p = 0; p < 4; p++) begin
         kc = {$urandom, $urandom};
         kl = 4'($urandom_range(1, MAX_KEY));
         if (p == 0) begin
            kc = '1;
            kl = 4'(MAX_KEY);
         end else if (p == 1) begin
            kl = 4'd0;
         end else if ($urandom_range(0, 1) == 0) begin
            for (int k = 0; k < 8; k++)
               kc[8*k +: 8] = 8'($urandom_range(8'h61, 8'h7A));
         end
         set_key(kc, kl);
         if (p == 2)
            hold_request = 1'b1;
         if (p == 3)
            quiet = 1'b1;
         start = live_bytes;
         docs  = 0;
         while (live_bytes - start < 20 || docs < 2) begin
            build_doc();
            send_doc();
            docs++;
         end
      end

      req.valid = 1'b0;
      wait (expected_locations.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
